>>> hdl/sdspi_pkg.sv
package sdspi_pkg;

  localparam int BlockBytesDefault   = 512;
  localparam int PowerupBytesDefault = 10;

  // Input commands
  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_RXB   = 3'd3,
    CMD_WDATA = 3'd4,
    CMD_TICK  = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    K_SEND  = 2'd0,
    K_RDATA = 2'd1,
    K_FAST  = 2'd2,
    K_DONE  = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_CMD_TO  = 2'd0;
  localparam logic [1:0] REG_DATA_TO = 2'd1;
  localparam logic [1:0] REG_INIT_TO = 2'd2;
  localparam logic [1:0] REG_RETRIES = 2'd3;

  // Phases, one-hot
  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_POWERUP  = 14'b00000000000010,
    PH_FRAME    = 14'b00000000000100,
    PH_RESP     = 14'b00000000001000,
    PH_REGBYTES = 14'b00000000010000,
    PH_TOKEN    = 14'b00000000100000,
    PH_RDATA    = 14'b00000001000000,
    PH_RCRC     = 14'b00000010000000,
    PH_WTOKEN   = 14'b00000100000000,
    PH_WPAY     = 14'b00001000000000,
    PH_WDATA    = 14'b00010000000000,
    PH_WCRC     = 14'b00100000000000,
    PH_DRESP    = 14'b01000000000000,
    PH_BUSY     = 14'b10000000000000
  } phase_t;

  // One result entry
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       sel;
    logic       st;
    logic       last;
  } result_t;

  // Accepted item passed from the front to the back
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] block_number;
    logic        count_ok;
    logic [7:0]  data_byte;
  } item_t;

  // CRC7 over the 40-bit command head (unrolled, constant input width)
  function automatic logic [6:0] crc7_of(input logic [39:0] bits);
    logic [6:0] c;
    logic fb;
    c = '0;
    for (int i = 39; i >= 0; i--) begin
      fb = c[6] ^ bits[i];
      c = {c[5:0], 1'b0};
      if (fb) c = c ^ 7'h09;
    end
    return c;
  endfunction

  // CRC16 CCITT, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> hdl/sdspi_front.sv
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] block_number,
  input  logic [15:0] block_count,
  input  logic [7:0]  data_byte,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int Depth = 2;

  item_t      mem [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      cls;

  // Classify: pre-check the block count so the back end compares one bit
  always_comb begin
    cls.cmd          = cmd_t'(cmd);
    cls.block_number = block_number;
    cls.count_ok     = (block_count == 16'd1);
    cls.data_byte    = data_byte;
  end

  assign in_stall = (fill == 2'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> hdl/sdspi_back.sv
module sdspi_back
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES   = BlockBytesDefault,
  parameter int POWERUP_BYTES = PowerupBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_res
);

  localparam int CntW = $clog2(BLOCK_BYTES + 1);

  // Configuration
  logic [15:0] cmd_to, data_to, init_to;
  logic [3:0]  retries;

  // State
  phase_t      phase, phase_next;
  logic [47:0] frame, frame_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic [3:0]  att, att_next;
  logic [15:0] el, el_next, lt, lt_next;
  logic [31:0] rsp, rsp_next;
  logic [15:0] crc, crc_next;
  logic        ready, ready_next, baddr, baddr_next, hcs, hcs_next;
  logic [5:0]  cur, cur_next;

  // Result buffer: up to two results per item, drained one per cycle while out_stall is low
  result_t     rb [3];
  logic [1:0]  rcnt, rpos;
  result_t     nr [3];
  logic [1:0]  nn;
  logic        busy_out;

  assign busy_out  = (rcnt != 2'd0);
  assign out_valid = busy_out;
  assign out_res   = rb[rpos];
  // Take a new item when buffer empty or its final entry leaves now
  assign q_pop = q_valid &&
                 (!busy_out || (!out_stall && (rpos == rcnt - 2'd1)));

  always_comb begin
    logic [39:0] head;
    logic [7:0]  c8;
    logic [7:0]  r1;
    logic        do_r1;
    logic [7:0]  b;
    logic [5:0]  ncmd;
    logic [31:0] narg;
    logic        scmd;
    logic        regs_go;

    phase_next = phase; frame_next = frame; cnt_next = cnt; att_next = att;
    el_next = el; lt_next = lt; rsp_next = rsp; crc_next = crc;
    ready_next = ready; baddr_next = baddr; hcs_next = hcs; cur_next = cur;
    nn = 2'd0;
    for (int i = 0; i < 3; i++) nr[i] = '{kind: K_SEND, data: 8'h00, sel: 1'b0, st: 1'b0, last: 1'b0};
    r1 = 8'hFF; do_r1 = 1'b0; scmd = 1'b0; ncmd = 6'd0; narg = 32'd0;
    regs_go = 1'b0; head = '0; c8 = 8'h01;
    b = q_item.data_byte;

    unique case (q_item.cmd)
      CMD_INIT: begin
        if (phase == PH_IDLE) begin
          ready_next = 1'b0; baddr_next = 1'b0; cnt_next = '0;
          phase_next = PH_POWERUP;
          nr[0] = '{K_SEND, 8'hFF, 1'b0, 1'b0, 1'b0}; nn = 2'd1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (phase == PH_IDLE) begin
          if (!ready || !q_item.count_ok) begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else begin
            scmd = 1'b1;
            ncmd = (q_item.cmd == CMD_WRITE) ? 6'd24 : 6'd17;
            narg = baddr ? q_item.block_number
                         : (q_item.block_number << $clog2(BLOCK_BYTES));
          end
        end
      end
      CMD_RXB: begin
        unique case (phase)
          PH_POWERUP: begin
            cnt_next = cnt + 1'b1;
            if (32'(cnt) + 1 < POWERUP_BYTES) begin
              nr[0] = '{K_SEND, 8'hFF, 1'b0, 1'b0, 1'b0}; nn = 2'd1;
            end else begin
              att_next = 4'd0;
              if (retries == 4'd0) begin
                phase_next = PH_IDLE;
                nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
              end else begin
                scmd = 1'b1; ncmd = 6'd0; narg = 32'd0;
              end
            end
          end
          PH_FRAME: begin
            cnt_next = cnt + 1'b1;
            if (cnt + 1'b1 < CntW'(6)) begin
              frame_next = {frame[39:0], 8'h00};
              nr[0] = '{K_SEND, frame[39:32], 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end else begin
              el_next = 16'd0; phase_next = PH_RESP;
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_RESP: begin
            if (!b[7]) begin
              do_r1 = 1'b1; r1 = b;
            end else if (el >= cmd_to) begin
              do_r1 = 1'b1; r1 = 8'hFF;
            end else begin
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_REGBYTES: begin
            rsp_next = {rsp[23:0], b};
            cnt_next = cnt + 1'b1;
            if (cnt + 1'b1 < CntW'(4)) begin
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end else if (cur == 6'd8) begin
              // Echo: voltage byte then check pattern, the last two received
              if (rsp[7:0] != 8'h01 || b != 8'hAA) begin
                phase_next = PH_IDLE;
                nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
              end else begin
                hcs_next = 1'b1; lt_next = 16'd0;
                scmd = 1'b1; ncmd = 6'd55; narg = 32'd0;
              end
            end else begin
              baddr_next = rsp[22];
              scmd = 1'b1; ncmd = 6'd16; narg = 32'(BLOCK_BYTES);
            end
          end
          PH_TOKEN: begin
            if (b == 8'hFE) begin
              cnt_next = '0; phase_next = PH_RDATA;
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end else if (el >= data_to) begin
              phase_next = PH_IDLE;
              nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
            end else begin
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_RDATA: begin
            nr[0] = '{K_RDATA, b, 1'b1, 1'b0, 1'b0};
            nr[1] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd2;
            cnt_next = cnt + 1'b1;
            if (32'(cnt) + 1 >= BLOCK_BYTES) begin
              cnt_next = '0; phase_next = PH_RCRC;
            end
          end
          PH_RCRC: begin
            cnt_next = cnt + 1'b1;
            if (cnt + 1'b1 < CntW'(2)) begin
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end else begin
              phase_next = PH_IDLE;
              nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_WTOKEN: begin
            crc_next = 16'd0; cnt_next = '0; phase_next = PH_WPAY;
          end
          PH_WDATA: begin
            cnt_next = cnt + 1'b1;
            if (32'(cnt) + 1 < BLOCK_BYTES) begin
              phase_next = PH_WPAY;
            end else begin
              cnt_next = '0; phase_next = PH_WCRC;
              nr[0] = '{K_SEND, crc[15:8], 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_WCRC: begin
            cnt_next = cnt + 1'b1;
            if (cnt + 1'b1 < CntW'(2)) begin
              nr[0] = '{K_SEND, crc[7:0], 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end else begin
              phase_next = PH_DRESP;
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_DRESP: begin
            if (b[4:0] != 5'h05) begin
              phase_next = PH_IDLE;
              nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
            end else begin
              el_next = 16'd0; phase_next = PH_BUSY;
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          PH_BUSY: begin
            if (b != 8'h00) begin
              phase_next = PH_IDLE;
              nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b0, 1'b0}; nn = 2'd1;
            end else if (el > data_to) begin
              phase_next = PH_IDLE;
              nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
            end else begin
              nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
            end
          end
          default: ;
        endcase
      end
      CMD_WDATA: begin
        if (phase == PH_WPAY) begin
          crc_next = crc16_byte(crc, b);
          phase_next = PH_WDATA;
          nr[0] = '{K_SEND, b, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
        end
      end
      CMD_TICK: begin
        if (el != 16'hFFFF) el_next = el + 16'd1;
        if (lt != 16'hFFFF) lt_next = lt + 16'd1;
      end
      default: ;
    endcase

    // R1 dispatch by current command
    if (do_r1) begin
      unique case (cur)
        6'd0: begin
          if (r1 == 8'h01) begin
            scmd = 1'b1; ncmd = 6'd8; narg = 32'h000001AA;
          end else begin
            att_next = att + 4'd1;
            if (att + 4'd1 < retries) begin
              scmd = 1'b1; ncmd = 6'd0; narg = 32'd0;
            end else begin
              phase_next = PH_IDLE;
              nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
            end
          end
        end
        6'd8: begin
          if (r1 == 8'h01) regs_go = 1'b1;
          else if (r1 == 8'h05) begin
            hcs_next = 1'b1; lt_next = 16'd0;
            scmd = 1'b1; ncmd = 6'd55; narg = 32'd0;
          end else begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end
        end
        6'd55: begin
          if (r1 > 8'h01) begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else begin
            scmd = 1'b1; ncmd = 6'd41; narg = hcs ? 32'h40000000 : 32'd0;
          end
        end
        6'd41: begin
          if (r1 == 8'h05) hcs_next = 1'b0;
          if (r1 > 8'h01 && r1 != 8'h05) begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else if (r1 != 8'h00 && lt < init_to) begin
            scmd = 1'b1; ncmd = 6'd55; narg = 32'd0;
          end else if (r1 != 8'h00) begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else begin
            scmd = 1'b1; ncmd = 6'd58; narg = 32'd0;
          end
        end
        6'd58: begin
          if (r1 == 8'h00) regs_go = 1'b1;
          else begin
            scmd = 1'b1; ncmd = 6'd16; narg = 32'(BLOCK_BYTES);
          end
        end
        6'd16: begin
          phase_next = PH_IDLE;
          if (r1 != 8'h00) begin
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else begin
            ready_next = 1'b1;
            nr[0] = '{K_FAST, 8'h00, 1'b0, 1'b0, 1'b0};
            nr[1] = '{K_DONE, 8'h00, 1'b0, 1'b0, 1'b0}; nn = 2'd2;
          end
        end
        6'd17: begin
          if (r1 != 8'h00) begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else begin
            el_next = 16'd0; phase_next = PH_TOKEN;
            nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
          end
        end
        default: begin
          if (r1 != 8'h00) begin
            phase_next = PH_IDLE;
            nr[0] = '{K_DONE, 8'h00, 1'b0, 1'b1, 1'b0}; nn = 2'd1;
          end else begin
            phase_next = PH_WTOKEN;
            nr[0] = '{K_SEND, 8'hFE, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
          end
        end
      endcase
    end

    // Start the register-bytes read of R7 or OCR
    if (regs_go) begin
      rsp_next = 32'd0; cnt_next = '0; phase_next = PH_REGBYTES;
      nr[0] = '{K_SEND, 8'hFF, 1'b1, 1'b0, 1'b0}; nn = 2'd1;
    end

    // Start a command frame
    if (scmd) begin
      head = {2'b01, ncmd, narg};
      c8 = (ncmd == 6'd0 || ncmd == 6'd8) ? {crc7_of(head), 1'b1} : 8'h01;
      cur_next = ncmd;
      frame_next = {head, c8};
      cnt_next = '0;
      phase_next = PH_FRAME;
      nr[0] = '{K_SEND, head[39:32], 1'b1, 1'b0, 1'b0}; nn = 2'd1;
    end

    // Flag the final result of this item
    if (nn != 2'd0) nr[nn - 2'd1].last = 1'b1;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_to <= 16'd100; data_to <= 16'd100; init_to <= 16'd1000; retries <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CMD_TO:  cmd_to  <= cfg_data;
        REG_DATA_TO: data_to <= cfg_data;
        REG_INIT_TO: init_to <= cfg_data;
        REG_RETRIES: retries <= cfg_data[3:0];
      endcase
    end
  end

  // Sequencer state and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; frame <= '0; cnt <= '0; att <= '0; el <= '0; lt <= '0;
      rsp <= '0; crc <= '0; ready <= 1'b0; baddr <= 1'b0; hcs <= 1'b1; cur <= '0;
      rcnt <= 2'd0; rpos <= 2'd0;
    end else begin
      if (q_pop) begin
        phase <= phase_next; frame <= frame_next; cnt <= cnt_next; att <= att_next;
        el <= el_next; lt <= lt_next; rsp <= rsp_next; crc <= crc_next;
        ready <= ready_next; baddr <= baddr_next; hcs <= hcs_next; cur <= cur_next;
        rcnt <= nn; rpos <= 2'd0;
      end else if (busy_out && !out_stall) begin
        if (rpos == rcnt - 2'd1) begin
          rcnt <= 2'd0; rpos <= 2'd0;
        end else begin
          rpos <= rpos + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) rb[i] <= nr[i];
    end
  end

endmodule

>>> hdl/sd_card_spi_host_sequencer_core.sv
// SD card host sequencer for SPI mode, one full-duplex byte per transaction.
// Input channel (in_valid/in_stall): cmd plus block_number, block_count and
// data_byte. Requests (init, read, write) start a sequence; each byte the
// block sends (kind 0) must be answered by a received-byte transaction with
// the byte clocked in. Write payload bytes and millisecond ticks also enter
// here. Output channel (out_valid/out_stall): kind, out_byte, select_card,
// status, last_of_run; one item gives zero to two results, the last one
// flagged by last_of_run.
// An accepted item enters a two-entry queue; the sequencer takes it from there
// and registers its results for output. One item is processed per cycle while
// each gives at most one result and out_stall is low; the sequencer takes no
// new item until the last result of the current one leaves the single result port.
// Reset clears the queue, the sequencer and the card state, and loads the
// default timeouts and retry count. When the receiver stalls, results hold,
// the queue fills and then in_stall rises.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while idle; the block does not enforce this.
module sd_card_spi_host_sequencer_core
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES   = BlockBytesDefault,
  parameter int POWERUP_BYTES = PowerupBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] block_number,
  input  logic [15:0] block_count,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic        select_card,
  output logic        status,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  sdspi_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .block_number, .block_count,
    .data_byte, .q_valid, .q_item, .q_pop
  );

  sdspi_back #(
    .BLOCK_BYTES(BLOCK_BYTES), .POWERUP_BYTES(POWERUP_BYTES)
  ) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop,
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .out_valid, .out_stall, .out_res(res)
  );

  assign kind        = res.kind;
  assign out_byte    = res.data;
  assign select_card = res.sel;
  assign status      = res.st;
  assign last_of_run = res.last;

endmodule
